// ===== rtl/bilevel_line_rotate_180_defines.svh =====
// assertion macros for the bilevel line rotate block
`ifndef BILEVEL_LINE_ROTATE_180_DEFINES_SVH
`define BILEVEL_LINE_ROTATE_180_DEFINES_SVH

`ifndef SYNTHESIS
`define BLR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("blr180 assertion failed");
`define BLR_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("blr180 assertion failed");
`else
`define BLR_ASSERT(label, prop)
`define BLR_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/blr180_pkg.sv =====
// shared types, constants and functions for the bilevel line rotate block
package blr180_pkg;

	localparam int LINE_BYTES_DEF = 512;

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int PAD_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BITS       = 1'd1;

	localparam logic [CFG_W-1:0] BYTES_PER_LINE_RST = 10'd512;
	localparam logic [PAD_W-1:0] PAD_BITS_RST       = 3'd0;

	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic             last;
		logic [PAD_W-1:0] pad;
	} emit_meta_t;

	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

endpackage

// ===== rtl/blr180_line_store.sv =====
// two-bank line store, one write port and two registered read ports
module blr180_line_store #(
	parameter int DEPTH = 2 * blr180_pkg::LINE_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [7:0]    rd_data_a,
	output logic [7:0]    rd_data_b
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_a_q;
	logic [7:0] rd_data_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_q <= mem[rd_addr_a];
			rd_data_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

// ===== rtl/blr180_emit.sv =====
// output stage: bit reversal, pad shift and output register
module blr180_emit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s1_vld,
	input  blr180_pkg::emit_meta_t  meta,
	input  logic [7:0]              cur_raw,
	input  logic [7:0]              nxt_raw,
	output logic                    s1_take,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_byte,
	output logic                    line_end
);

	logic        out_vld_q;
	logic [7:0]  out_byte_q;
	logic        line_end_q;
	logic [7:0]  cur;
	logic [7:0]  nxt;
	logic [15:0] joined;

	assign s1_take = s1_vld && (!out_vld_q || !out_stall);

	always_comb begin
		cur    = blr180_pkg::flip8(cur_raw);
		nxt    = meta.last ? 8'h00 : blr180_pkg::flip8(nxt_raw);
		joined = {cur, nxt} << meta.pad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_take) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			out_byte_q <= joined[15:8];
			line_end_q <= meta.last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_byte  = out_byte_q;
	assign line_end  = line_end_q;

endmodule

// ===== rtl/bilevel_line_rotate_180.sv =====
// top level of the bilevel line rotate block
// an emitting request reads the store into its registered read data; the emit stage then registers the output byte
// throughput: one request per cycle while in_stall is low
// a line becomes pending on its last data byte; each later request emits one byte while the line is pending
// reset clears all control state; the line store holds no reset value
// after reset bytes_per_line is 512 and pad_bits is 0
`include "bilevel_line_rotate_180_defines.svh"

module bilevel_line_rotate_180 #(
	parameter int LINE_BYTES = blr180_pkg::LINE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_en,
	input  logic [blr180_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [blr180_pkg::CFG_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [7:0]                        src_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        out_byte,
	output logic                              line_end
);

	localparam int IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam int LEN_W = $clog2(LINE_BYTES + 1);
	localparam int CMP_W = (LEN_W > blr180_pkg::CFG_W) ? LEN_W : blr180_pkg::CFG_W;
	localparam int DEPTH = 2 * LINE_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [CMP_W-1:0] LINE_BYTES_C = CMP_W'(LINE_BYTES);
	localparam logic [IDX_W-1:0] LAST_IDX_C   = IDX_W'(LINE_BYTES - 1);
	localparam logic [AW-1:0]    BANK1_BASE   = AW'(LINE_BYTES);

	logic [blr180_pkg::CFG_W-1:0] bytes_per_line_q;
	logic [blr180_pkg::PAD_W-1:0] pad_bits_q;
	logic [IDX_W-1:0]             write_index_q;
	logic                         write_bank_q;
	logic [IDX_W-1:0]             read_index_q;
	logic                         pending_q;

	logic                         vld_s1;
	blr180_pkg::emit_meta_t       meta_s1;

	logic [CMP_W-1:0] bpl_ext;
	logic [IDX_W-1:0] lenm1;
	logic [IDX_W-1:0] k;
	logic             last;
	logic [IDX_W-1:0] cur_idx;
	logic [IDX_W-1:0] nxt_idx;
	logic [AW-1:0]    rd_addr_a;
	logic [AW-1:0]    rd_addr_b;
	logic [AW-1:0]    wr_addr;
	logic             acc;
	logic             emit;
	logic             wr;
	logic             line_done;
	logic             s1_take;
	logic [7:0]       cur_raw;
	logic [7:0]       nxt_raw;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_line_q <= blr180_pkg::BYTES_PER_LINE_RST;
			pad_bits_q       <= blr180_pkg::PAD_BITS_RST;
		end else if (cfg_en) begin
			case (cfg_addr)
				blr180_pkg::REG_BYTES_PER_LINE: bytes_per_line_q <= cfg_data;
				blr180_pkg::REG_PAD_BITS: pad_bits_q <= cfg_data[blr180_pkg::PAD_W-1:0];
				default: ;
			endcase
		end
	end

	// effective line length minus one
	assign bpl_ext = CMP_W'(bytes_per_line_q);

	always_comb begin
		if (bytes_per_line_q == '0) begin
			lenm1 = '0;
		end else if (bpl_ext > LINE_BYTES_C) begin
			lenm1 = LAST_IDX_C;
		end else begin
			lenm1 = IDX_W'(bpl_ext - CMP_W'(1));
		end
	end

	// read and write side addressing
	always_comb begin
		k       = (read_index_q >= lenm1) ? lenm1 : read_index_q;
		last    = (k == lenm1);
		cur_idx = lenm1 - k;
		nxt_idx = cur_idx - IDX_W'(1);
		if (write_bank_q) begin
			rd_addr_a = AW'(cur_idx);
			rd_addr_b = AW'(nxt_idx);
			wr_addr   = BANK1_BASE + AW'(write_index_q);
		end else begin
			rd_addr_a = BANK1_BASE + AW'(cur_idx);
			rd_addr_b = BANK1_BASE + AW'(nxt_idx);
			wr_addr   = AW'(write_index_q);
		end
	end

	assign in_stall  = vld_s1 && !s1_take;
	assign acc       = in_valid && !in_stall;
	assign emit      = acc && pending_q;
	assign wr        = acc && (req_type == blr180_pkg::REQ_DATA);
	assign line_done = write_index_q >= lenm1;

	// line control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			write_bank_q  <= 1'b0;
			read_index_q  <= '0;
			pending_q     <= 1'b0;
		end else if (wr && line_done) begin
			write_bank_q  <= ~write_bank_q;
			write_index_q <= '0;
			pending_q     <= 1'b1;
			read_index_q  <= '0;
		end else begin
			if (emit) begin
				if (last) begin
					pending_q    <= 1'b0;
					read_index_q <= '0;
				end else begin
					read_index_q <= k + IDX_W'(1);
				end
			end
			if (wr) begin
				write_index_q <= write_index_q + IDX_W'(1);
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (emit) begin
			vld_s1 <= 1'b1;
		end else if (s1_take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			meta_s1.last <= last;
			meta_s1.pad  <= pad_bits_q;
		end
	end

	blr180_line_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk      (clk),
		.wr_en    (wr),
		.wr_addr  (wr_addr),
		.wr_data  (src_byte),
		.rd_en    (emit),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(cur_raw),
		.rd_data_b(nxt_raw)
	);

	blr180_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_vld   (vld_s1),
		.meta     (meta_s1),
		.cur_raw  (cur_raw),
		.nxt_raw  (nxt_raw),
		.s1_take  (s1_take),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.line_end (line_end)
	);

	`BLR_ASSERT(a_idle_read_index, !pending_q |-> read_index_q == '0)
	`BLR_ASSERT(a_stall_only_when_full, in_stall |-> vld_s1 && out_valid && out_stall)
	`BLR_ASSERT(a_emit_fills_s1, emit |=> vld_s1)
	`BLR_ASSERT(a_write_index_range, write_index_q <= LAST_IDX_C)

endmodule
